>>> sv/aps_pkg.sv
// ----------------------------------------------------------------------------
// Aligned pulse scheduler package
// Shared widths, constants, register indexes and sequencer states.
// ----------------------------------------------------------------------------
package aps_pkg;

    localparam int unsigned NS_W      = 30;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned CNT_W     = 5;

    localparam logic [NS_W:0] NS_PER_SECOND = (NS_W + 1)'(1000000000);

    localparam logic [NS_W-1:0] PULSE_INTERVAL_RESET = NS_W'(1000000000);
    localparam logic [NS_W-1:0] FIRE_WINDOW_RESET    = '0;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_PULSE_INTERVAL = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_FIRE_WINDOW    = CFG_IDX_W'(1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_GRID,
        ST_COMMIT
    } aps_state_t;

endpackage

>>> sv/aligned_pulse_scheduler_unit.sv
// ----------------------------------------------------------------------------
// Aligned pulse scheduler
// Decides per timestamp item whether a grid-aligned pulse is due and
// reschedules the next pulse time.
// ----------------------------------------------------------------------------
// Each input item is a nanosecond-of-second sample. A sample that is still
// before the scheduled pulse time and has not wrapped below the previous
// sample is ignored: the result reports fire = 0 and the unchanged pulse time.
// Such an item goes from the accept step straight to the commit of the result.
// Any other sample fires if it is no later than the pulse time plus the fire
// window, and the block then moves the pulse time to the next multiple of
// pulse_interval above the sample, wrapping to zero at one second. That
// item is accepted, loads the restoring remainder unit, runs through that
// unit (one quotient bit per cycle), waits for its done flag, forms the grid
// point and commits the result. The next item can be taken once the result
// is committed. A stalled output register holds the item in the commit
// state until the register is free. The next grid point is built as
// sample - (sample mod interval) + interval, so no multiplier is needed.
// An interval of zero schedules the pulse at zero.
// The block takes one item at a time and holds in_stall high until the
// current item is committed; a finished result waits in an output register
// while the next item is accepted. Configuration writes are always ready and
// are meant to happen only while the block is idle.
module aligned_pulse_scheduler_unit
    import aps_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    // Configuration write channel
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [NS_W-1:0]      cfg_data,
    // Sample input channel
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [NS_W-1:0]      sample_ns,
    // Result output channel
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic                 fire,
    output logic [NS_W-1:0]      next_pulse_ns
);

    aps_state_t state_reg, state_next;

    logic [NS_W-1:0] interval_reg, interval_next;
    logic [NS_W-1:0] window_reg, window_next;
    logic [NS_W-1:0] pulse_time_reg, pulse_time_next;
    logic [NS_W-1:0] last_sample_reg, last_sample_next;

    logic [NS_W-1:0] sample_reg, sample_next;
    logic            ignore_reg, ignore_next;
    logic            fire_item_reg, fire_item_next;
    logic [NS_W-1:0] grid_reg, grid_next;

    logic            out_valid_reg, out_valid_next;
    logic            out_fire_reg, out_fire_next;
    logic [NS_W-1:0] out_pulse_reg, out_pulse_next;

    logic            divide_entry_reg;
    logic            div_done;
    logic [NS_W-1:0] div_rem;

    logic            in_accept;
    logic            out_free;
    logic [NS_W:0]   fire_limit;
    logic [NS_W:0]   grid_sum;

    aps_rem_unit u_rem (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (divide_entry_reg),
        .dividend  (sample_reg),
        .divisor   (interval_reg),
        .done      (div_done),
        .remainder (div_rem)
    );

    assign cfg_ready = 1'b1;
    assign in_stall  = (state_reg != ST_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;

    // The fire limit is formed one bit wider so it cannot wrap.
    assign fire_limit = {1'b0, pulse_time_reg} + {1'b0, window_reg};

    // Next multiple strictly above the sample; the remainder is at most the
    // sample, so the difference never borrows.
    assign grid_sum = {1'b0, sample_reg} - {1'b0, div_rem} + {1'b0, interval_reg};

    // Configuration registers.
    always_comb
    begin
        interval_next = interval_reg;
        window_next   = window_reg;
        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_PULSE_INTERVAL: interval_next = cfg_data;
                REG_FIRE_WINDOW:    window_next   = cfg_data;
                default:            ;
            endcase
        end
    end

    // Sequencer.
    always_comb
    begin
        state_next       = state_reg;
        sample_next      = sample_reg;
        ignore_next      = ignore_reg;
        fire_item_next   = fire_item_reg;
        grid_next        = grid_reg;
        pulse_time_next  = pulse_time_reg;
        last_sample_next = last_sample_reg;
        out_valid_next   = out_valid_reg && out_stall;
        out_fire_next    = out_fire_reg;
        out_pulse_next   = out_pulse_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    sample_next    = sample_ns;
                    ignore_next    = (sample_ns < pulse_time_reg) &&
                                     (sample_ns >= last_sample_reg);
                    fire_item_next = ({1'b0, sample_ns} <= fire_limit);
                    if ((sample_ns < pulse_time_reg) && (sample_ns >= last_sample_reg))
                    begin
                        state_next = ST_COMMIT;
                    end
                    else
                    begin
                        state_next = ST_DIVIDE;
                    end
                end
            end
            ST_DIVIDE:
            begin
                // The unit is started on entry and reports done once its last bit step is through.
                if (div_done)
                begin
                    state_next = ST_GRID;
                end
            end
            ST_GRID:
            begin
                if ((interval_reg == '0) || (grid_sum >= NS_PER_SECOND))
                begin
                    grid_next = '0;
                end
                else
                begin
                    grid_next = grid_sum[NS_W-1:0];
                end
                state_next = ST_COMMIT;
            end
            ST_COMMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    if (ignore_reg)
                    begin
                        out_fire_next  = 1'b0;
                        out_pulse_next = pulse_time_reg;
                    end
                    else
                    begin
                        out_fire_next    = fire_item_reg;
                        out_pulse_next   = grid_reg;
                        pulse_time_next  = grid_reg;
                        last_sample_next = (sample_reg > grid_reg) ? grid_reg : sample_reg;
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Kick the remainder unit in the first cycle of the divide state, once the
    // sample register holds the accepted sample.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            divide_entry_reg <= 1'b0;
        end
        else
        begin
            divide_entry_reg <= (state_reg != ST_DIVIDE) && (state_next == ST_DIVIDE);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            interval_reg    <= PULSE_INTERVAL_RESET;
            window_reg      <= FIRE_WINDOW_RESET;
            pulse_time_reg  <= '0;
            last_sample_reg <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            interval_reg    <= interval_next;
            window_reg      <= window_next;
            pulse_time_reg  <= pulse_time_next;
            last_sample_reg <= last_sample_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sample_reg    <= sample_next;
        ignore_reg    <= ignore_next;
        fire_item_reg <= fire_item_next;
        grid_reg      <= grid_next;
        out_fire_reg  <= out_fire_next;
        out_pulse_reg <= out_pulse_next;
    end

    assign out_valid     = out_valid_reg;
    assign fire          = out_fire_reg;
    assign next_pulse_ns = out_pulse_reg;

endmodule

>>> sv/aps_rem_unit.sv
// ----------------------------------------------------------------------------
// Aligned pulse scheduler remainder unit
// Restoring divider that produces dividend modulo divisor, one bit a cycle.
// ----------------------------------------------------------------------------
module aps_rem_unit
    import aps_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  logic [NS_W-1:0] dividend,
    input  logic [NS_W-1:0] divisor,
    output logic            done,
    output logic [NS_W-1:0] remainder
);

    logic            busy_reg, busy_next;
    logic            done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [NS_W-1:0] shift_reg, shift_next;
    logic [NS_W-1:0] rem_reg, rem_next;
    logic [NS_W-1:0] divisor_reg, divisor_next;

    logic [NS_W:0] trial;
    logic [NS_W:0] diff;

    // The partial remainder stays below the divisor, so the shifted trial
    // value fits in one extra bit.
    assign trial = {rem_reg, shift_reg[NS_W-1]};
    assign diff  = trial - {1'b0, divisor_reg};

    always_comb
    begin
        busy_next    = busy_reg;
        done_next    = 1'b0;
        cnt_next     = cnt_reg;
        shift_next   = shift_reg;
        rem_next     = rem_reg;
        divisor_next = divisor_reg;
        if (start)
        begin
            busy_next    = 1'b1;
            cnt_next     = '0;
            shift_next   = dividend;
            rem_next     = '0;
            divisor_next = divisor;
        end
        else if (busy_reg)
        begin
            shift_next = {shift_reg[NS_W-2:0], 1'b0};
            if (trial >= {1'b0, divisor_reg})
            begin
                rem_next = diff[NS_W-1:0];
            end
            else
            begin
                rem_next = trial[NS_W-1:0];
            end
            cnt_next = cnt_reg + CNT_W'(1);
            if (cnt_reg == CNT_W'(NS_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        shift_reg   <= shift_next;
        rem_reg     <= rem_next;
        divisor_reg <= divisor_next;
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule

>>> tb/aps_schedule_checker.sv
// ----------------------------------------------------------------------------
// Aligned pulse scheduler checker
// Watches the configuration, sample and result channels of the scheduler,
// predicts the fire flag and next pulse time of every accepted sample, and
// compares each accepted result with the oldest prediction.
// ----------------------------------------------------------------------------
module aps_schedule_checker
    import aps_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    input  logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [NS_W-1:0]      cfg_data,
    input  logic                 in_valid,
    input  logic                 in_stall,
    input  logic [NS_W-1:0]      sample_ns,
    input  logic                 out_valid,
    input  logic                 out_stall,
    input  logic                 fire,
    input  logic [NS_W-1:0]      next_pulse_ns,
    output int                   results_awaited,
    output int                   result_failures
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic            fire;
        logic [NS_W-1:0] next_pulse;
    } pulse_decision_t;

    logic [NS_W-1:0] interval_ns;
    logic [NS_W-1:0] window_ns;
    logic [NS_W-1:0] pulse_at;
    logic [NS_W-1:0] prev_sample;

    pulse_decision_t awaited_decisions[$];
    pulse_decision_t oldest;
    int              mismatches = 0;

    // First grid point strictly above t; zero when the step gives no grid
    // or the point would reach one second.
    function automatic logic [NS_W-1:0] grid_after(logic [NS_W-1:0] t,
                                                    logic [NS_W-1:0] step);
        longint unsigned nxt;
        if (step == '0)
            return '0;
        nxt = ((64'(t) / 64'(step)) + 64'd1) * 64'(step);
        if (nxt >= 64'(NS_PER_SECOND))
            return '0;
        return NS_W'(nxt);
    endfunction

    function automatic pulse_decision_t decide_pulse(logic [NS_W-1:0] t);
        pulse_decision_t d;
        d.fire = 1'b0;
        // A sample before the pulse that has not wrapped leaves all state alone.
        if (!(t < pulse_at && t >= prev_sample)) begin
            d.fire      = ({1'b0, t} <= ({1'b0, pulse_at} + {1'b0, window_ns}));
            pulse_at    = grid_after(t, interval_ns);
            prev_sample = (t > pulse_at) ? pulse_at : t;
        end
        d.next_pulse = pulse_at;
        return d;
    endfunction

    always @(posedge clk) begin
        if (!rst_n) begin
            interval_ns = PULSE_INTERVAL_RESET;
            window_ns   = FIRE_WINDOW_RESET;
            pulse_at    = '0;
            prev_sample = '0;
            awaited_decisions.delete();
        end else begin
            if (out_valid && !out_stall) begin
                if (awaited_decisions.size() == 0) begin
                    $error("result with nothing awaited: fire=%0d next_pulse_ns=%0d",
                           fire, next_pulse_ns);
                    mismatches++;
                end else begin
                    oldest = awaited_decisions.pop_front();
                    if (fire !== oldest.fire) begin
                        $error("fire: expected %0d, actual %0d", oldest.fire, fire);
                        mismatches++;
                    end
                    if (next_pulse_ns !== oldest.next_pulse) begin
                        $error("next_pulse_ns: expected %0d, actual %0d",
                               oldest.next_pulse, next_pulse_ns);
                        mismatches++;
                    end
                end
            end
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_PULSE_INTERVAL: interval_ns = cfg_data;
                    REG_FIRE_WINDOW:    window_ns   = cfg_data;
                    default:            ;
                endcase
            end
            if (in_valid && !in_stall)
                awaited_decisions.push_back(decide_pulse(sample_ns));
        end
        results_awaited <= awaited_decisions.size();
        result_failures <= mismatches;
    end

endmodule

>>> tb/aligned_pulse_scheduler_unit_test.sv
// ----------------------------------------------------------------------------
// Aligned pulse scheduler testbench
// Drives timestamp samples and register settings into the scheduler, with
// random idle gaps and stalls on both sides, and leaves prediction and
// comparison to the checker instantiated beside the block.
// ----------------------------------------------------------------------------
module aligned_pulse_scheduler_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    import aps_pkg::*;

    localparam int unsigned RANDOM_ITEMS = 650;
    localparam int unsigned PHASES       = 6;
    localparam int unsigned HOLD_CYCLES  = 300;
    localparam int unsigned DRAIN_CYCLES = 40;
    localparam int unsigned CYCLE_LIMIT  = 600000;

    localparam logic [NS_W-1:0]      ALL_ONES   = '1;
    localparam logic [NS_W-1:0]      ONE_SECOND = NS_W'(NS_PER_SECOND);
    localparam logic [NS_W-1:0]      LAST_NS    = NS_W'(999999999);
    // An index that names no register; a write to it must change nothing.
    localparam logic [CFG_IDX_W-1:0] REG_SPARE  = CFG_IDX_W'(2);

    logic                 clk           = 1'b0;
    logic                 rst_n         = 1'b0;
    logic                 cfg_valid     = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index     = '0;
    logic [NS_W-1:0]      cfg_data      = '0;
    logic                 in_valid      = 1'b0;
    logic                 in_stall;
    logic [NS_W-1:0]      sample_ns     = '0;
    logic                 out_valid;
    logic                 out_stall     = 1'b0;
    logic                 fire;
    logic [NS_W-1:0]      next_pulse_ns;

    int results_awaited;
    int result_failures;

    // Set by the stimulus to make the result side hold off for a long stretch.
    bit hold_off_req = 1'b0;
    // Number of upcoming items the sample side sends without any gap.
    int burst_left   = 0;

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    aligned_pulse_scheduler_unit i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .sample_ns     (sample_ns),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .fire          (fire),
        .next_pulse_ns (next_pulse_ns)
    );

    aps_schedule_checker i_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .sample_ns       (sample_ns),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .fire            (fire),
        .next_pulse_ns   (next_pulse_ns),
        .results_awaited (results_awaited),
        .result_failures (result_failures)
    );

    // Length of one idle stretch: mostly a few cycles, now and then a long one.
    function automatic int idle_cycles();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 60)
            return $urandom_range(1, 3);
        else if (roll < 95)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // Offers one sample and returns at the edge where it is taken. The valid
    // stays high when no gap follows, so back-to-back items need no toggle.
    task automatic send_sample(input logic [NS_W-1:0] value);
        int gap;
        in_valid  <= 1'b1;
        sample_ns <= value;
        do @(posedge clk); while (in_stall);
        gap = 0;
        if (burst_left > 0)
            burst_left--;
        else if ($urandom_range(0, 19) == 0)
            burst_left = $urandom_range(10, 40);
        else if ($urandom_range(0, 1) == 0)
            gap = idle_cycles();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Stops offering samples and waits until every predicted result is back.
    // The first edge is always waited so that the checker has seen the last
    // accepted sample before its count is read.
    task automatic wait_drained();
        in_valid <= 1'b0;
        do @(posedge clk); while (results_awaited != 0);
        repeat (4) @(posedge clk);
    endtask

    // Writes both registers back to back; the block must be idle.
    task automatic apply_setting(input logic [NS_W-1:0] interval,
                                 input logic [NS_W-1:0] window);
        cfg_valid <= 1'b1;
        cfg_index <= REG_PULSE_INTERVAL;
        cfg_data  <= interval;
        do @(posedge clk); while (!cfg_ready);
        cfg_index <= REG_FIRE_WINDOW;
        cfg_data  <= window;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // Result side: alternating runs of acceptance and stall, with occasional
    // long stretches of no stall at all. When the stimulus asks for it, the
    // stall is held for a fixed number of cycles so the block backs up.
    initial begin
        int run_left;
        bit stalled;
        run_left = 0;
        stalled  = 1'b0;
        forever begin
            @(posedge clk);
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                run_left = 0;
                stalled  = 1'b1;
            end else begin
                if (run_left == 0) begin
                    if (stalled || $urandom_range(0, 1) == 0) begin
                        stalled  = 1'b0;
                        run_left = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 150)
                                                                : $urandom_range(1, 12);
                    end else begin
                        stalled  = 1'b1;
                        run_left = idle_cycles();
                    end
                end
                out_stall <= stalled;
                run_left--;
            end
        end
    end

    // Watchdog: a run that does not finish within the limit has hung.
    initial begin
        int unsigned cycle_count;
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("FAILURE");
        $finish;
    end

    initial begin
        logic [NS_W-1:0] interval_ns;
        logic [NS_W-1:0] window_ns;
        longint unsigned clock_ns;
        int unsigned     span;
        int unsigned     step;
        int unsigned     back;
        int unsigned     per_phase;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Reset setting: one pulse per second at zero and no fire window.
        // Covers the zero sample, the last nanosecond of the second, and a
        // sample of one second or more, which wraps the schedule to zero.
        send_sample('0);
        send_sample(NS_W'(500));
        send_sample(LAST_NS);
        send_sample(ALL_ONES);
        send_sample('0);
        wait_drained();

        // A write to an unused index must leave both registers unchanged;
        // the valid is left high because the next writes follow at once.
        cfg_valid <= 1'b1;
        cfg_index <= REG_SPARE;
        cfg_data  <= ALL_ONES;
        do @(posedge clk); while (!cfg_ready);

        // An interval of 100 with no window: a sample exactly on the
        // pulse, an ignored early sample, a late one outside the window, and
        // a wrap below the previous sample.
        apply_setting(NS_W'(100), '0);
        send_sample('0);
        send_sample(NS_W'(50));
        send_sample(NS_W'(100));
        send_sample(NS_W'(250));
        send_sample(NS_W'(299));
        send_sample(NS_W'(5));
        wait_drained();

        // Zero interval gives no grid, so the pulse is always scheduled at zero.
        // The widest window checks that pulse time plus window cannot wrap.
        apply_setting('0, ALL_ONES);
        send_sample(NS_W'(123456789));
        send_sample(LAST_NS);
        wait_drained();

        // An interval that does not divide one second: grid points past the
        // second must wrap to zero.
        apply_setting(NS_W'(333333333), ONE_SECOND);
        send_sample(NS_W'(700000000));
        send_sample(LAST_NS);
        send_sample(ALL_ONES);
        wait_drained();

        // Interval beyond one second: the first grid point already wraps.
        apply_setting(ALL_ONES, NS_W'(50));
        send_sample(NS_W'(1));
        send_sample(NS_W'(2));
        wait_drained();

        // Random phases. Each phase picks a setting and then mostly plays a
        // clock that moves forward and wraps at one second, so that pulses
        // come due, get missed and wrap around. A fifth of the samples are
        // noise: arbitrary 30-bit values or jumps back in time.
        per_phase = RANDOM_ITEMS / PHASES;
        for (int ph = 0; ph < PHASES; ph++) begin
            case ($urandom_range(0, 11))
                0:       interval_ns = NS_W'(100);
                1:       interval_ns = NS_W'(1000);
                2:       interval_ns = NS_W'(8000);
                3:       interval_ns = NS_W'(250000);
                4:       interval_ns = NS_W'(1000000);
                5:       interval_ns = NS_W'(500000000);
                6:       interval_ns = ONE_SECOND;
                7:       interval_ns = NS_W'($urandom_range(100, 1000000));
                8:       interval_ns = NS_W'(125);
                9:       interval_ns = '0;
                10:      interval_ns = ALL_ONES;
                default: interval_ns = NS_W'(200000000);
            endcase
            // Without a usable grid the clock still needs a sensible stride.
            span = (interval_ns == '0 || interval_ns > ONE_SECOND) ? 300000000
                                                                   : interval_ns;
            case ($urandom_range(0, 5))
                0:       window_ns = '0;
                1:       window_ns = NS_W'($urandom_range(0, span / 8));
                2:       window_ns = NS_W'(span / 2);
                3:       window_ns = NS_W'(span);
                4:       window_ns = ONE_SECOND;
                default: window_ns = ALL_ONES;
            endcase
            wait_drained();
            apply_setting(interval_ns, window_ns);

            clock_ns = $urandom_range(0, 999999999);
            for (int n = 0; n < per_phase; n++) begin
                // Twice in the run the result side holds off while samples keep
                // coming at full rate, so the block fills and stalls its input.
                if (n == 20 && (ph == 1 || ph == 4)) begin
                    hold_off_req = 1'b1;
                    burst_left   = 40;
                end
                // Now and then the sample side pauses until all results are in.
                if ($urandom_range(0, 49) == 0)
                    wait_drained();

                case ($urandom_range(0, 9))
                    8: send_sample(NS_W'($urandom));
                    9: begin
                        back     = $urandom_range(0, span);
                        clock_ns = (back > clock_ns) ? 0 : clock_ns - back;
                        send_sample(NS_W'(clock_ns));
                    end
                    default: begin
                        step = ($urandom_range(0, 3) == 0) ? $urandom_range(0, span / 16)
                                                           : $urandom_range(0, span + span / 2);
                        clock_ns = (clock_ns + step) % 64'(NS_PER_SECOND);
                        send_sample(NS_W'(clock_ns));
                    end
                endcase
            end
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (result_failures == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
